### hw/rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// LBA to CHS planner package
// Types, register indexes and geometry helpers shared by the planner modules.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 14;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE      = 2'd2;

  localparam logic [8:0] RST_HEAD_COUNT = 9'd16;
  localparam logic [5:0] RST_SPT        = 6'd63;
  localparam logic [7:0] RST_DRIVE      = 8'd128;

  localparam logic [1:0] FUNC_READ_HI  = 2'b10;
  localparam logic [1:0] FUNC_WRITE_HI = 2'b11;
  localparam logic       CMD_WRITE     = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] start_sector;
    logic [5:0]  request_sectors;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  function_word;
    logic [15:0] cyl_sector_word;
    logic [15:0] head_drive_word;
    logic [9:0]  cylinder;
    logic [7:0]  head;
    logic [5:0]  sector;
    logic [5:0]  run_sectors;
    logic [4:0]  buffer_offset;
    logic        last;
    logic        cylinder_overflow;
  } out_item_t;

  typedef struct packed {
    logic [8:0] heads;
    logic [5:0] spt;
    logic [7:0] drive;
  } geo_t;

  typedef struct packed {
    logic       cmd;
    logic [9:0] cyl;
    logic       cyl_ovf;
    logic [7:0] head;
    logic [5:0] sect;
    logic [5:0] count;
  } plan_t;

  function automatic logic [8:0] eff_heads(input logic [8:0] h);
    logic [8:0] r;
    if (h == 9'd0) r = 9'd1;
    else if (h > 9'd256) r = 9'd256;
    else r = h;
    return r;
  endfunction

  function automatic logic [5:0] eff_spt(input logic [5:0] s);
    return (s == 6'd0) ? 6'd1 : s;
  endfunction

endpackage

### hw/rtl/ltc_div.sv
// ----------------------------------------------------------------------------
// LBA to CHS iterative divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module ltc_div
  import ltc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("Divider started while busy.");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dvs_r)
    else $error("Divider remainder not below divisor.");

endmodule

### hw/rtl/ltc_front.sv
// ----------------------------------------------------------------------------
// LBA to CHS front end
// Accepts requests and resolves the start sector to cylinder, head and sector.
// ----------------------------------------------------------------------------
module ltc_front
  import ltc_pkg::*;
#(
  parameter int MAX_SECTORS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  input  geo_t     geo,
  output logic     q_push,
  input  logic     q_full,
  output plan_t    q_data
);

  typedef enum logic [4:0] {
    F_IDLE      = 5'b00001,
    F_CYL_GO    = 5'b00010,
    F_CYL_WAIT  = 5'b00100,
    F_HEAD_WAIT = 5'b01000,
    F_PUSH      = 5'b10000
  } fstate_t;

  localparam logic [6:0] MaxCnt = 7'(MAX_SECTORS);

  fstate_t          state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [5:0]       count_r, count_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [DVS_W-1:0] per_cyl_r, per_cyl_nxt;
  logic [9:0]       cyl_r, cyl_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       head_r, head_nxt;
  logic [5:0]       sect_r, sect_nxt;
  logic [5:0]       sat_cnt;
  logic [14:0]      product;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  ltc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign sat_cnt = ({1'b0, in_data.request_sectors} > MaxCnt) ? 6'(MAX_SECTORS)
                                                              : in_data.request_sectors;
  assign product = geo.heads * geo.spt;
  assign full    = state_r != F_IDLE;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    start_nxt    = start_r;
    per_cyl_nxt  = per_cyl_r;
    cyl_nxt      = cyl_r;
    ovf_nxt      = ovf_r;
    head_nxt     = head_r;
    sect_nxt     = sect_r;
    div_start    = 1'b0;
    div_dividend = start_r;
    div_divisor  = per_cyl_r;
    q_push       = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (push) begin
          cmd_nxt     = in_data.cmd;
          count_nxt   = sat_cnt;
          start_nxt   = in_data.start_sector;
          per_cyl_nxt = product[DVS_W-1:0];
          if (sat_cnt != 6'd0) state_nxt = F_CYL_GO;
        end
      end
      F_CYL_GO: begin
        div_start = 1'b1;
        state_nxt = F_CYL_WAIT;
      end
      F_CYL_WAIT: begin
        if (div_done) begin
          cyl_nxt      = div_quo[9:0];
          ovf_nxt      = |div_quo[DIV_W-1:10];
          div_start    = 1'b1;
          div_dividend = DIV_W'(div_rem);
          div_divisor  = DVS_W'(geo.spt);
          state_nxt    = F_HEAD_WAIT;
        end
      end
      F_HEAD_WAIT: begin
        if (div_done) begin
          head_nxt  = div_quo[7:0];
          sect_nxt  = div_rem[5:0];
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r     <= cmd_nxt;
    count_r   <= count_nxt;
    start_r   <= start_nxt;
    per_cyl_r <= per_cyl_nxt;
    cyl_r     <= cyl_nxt;
    ovf_r     <= ovf_nxt;
    head_r    <= head_nxt;
    sect_r    <= sect_nxt;
  end

  assign q_data = '{cmd: cmd_r, cyl: cyl_r, cyl_ovf: ovf_r, head: head_r,
                    sect: sect_r, count: count_r};

endmodule

### hw/rtl/ltc_queue.sv
// ----------------------------------------------------------------------------
// LBA to CHS plan queue
// Two-entry queue of resolved requests between the front and back ends.
// ----------------------------------------------------------------------------
module ltc_queue
  import ltc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  plan_t wdata,
  input  logic  pop,
  output logic  empty,
  output plan_t rdata
);

  plan_t      mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) mem_r[wptr_r] <= wdata;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("Plan queue written while full.");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("Plan queue read while empty.");

endmodule

### hw/rtl/ltc_back.sv
// ----------------------------------------------------------------------------
// LBA to CHS back end
// Splits each resolved request into track runs and packs the BIOS words.
// ----------------------------------------------------------------------------
module ltc_back
  import ltc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  plan_t     q_data,
  input  logic      q_empty,
  output logic      q_pop,
  input  geo_t      geo,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic       busy_r, busy_nxt;
  logic       cmd_r, cmd_nxt;
  logic [9:0] cyl_r, cyl_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] head_r, head_nxt;
  logic [5:0] sect_r, sect_nxt;
  logic [5:0] left_r, left_nxt;
  logic [5:0] done_r, done_nxt;
  logic       ovalid_r, ovalid_nxt;
  out_item_t  out_r, out_nxt;
  logic [5:0] room;
  logic [5:0] run;
  logic       fin;
  logic       load;
  logic [8:0] head_inc;

  assign room     = geo.spt - sect_r;
  assign run      = (room < left_r) ? room : left_r;
  assign fin      = run == left_r;
  assign load     = busy_r && (!ovalid_r || pop);
  assign q_pop    = !busy_r && !q_empty;
  assign head_inc = {1'b0, head_r} + 9'd1;

  always_comb begin
    busy_nxt   = busy_r;
    cmd_nxt    = cmd_r;
    cyl_nxt    = cyl_r;
    ovf_nxt    = ovf_r;
    head_nxt   = head_r;
    sect_nxt   = sect_r;
    left_nxt   = left_r;
    done_nxt   = done_r;
    ovalid_nxt = ovalid_r;
    out_nxt    = out_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      cmd_nxt  = q_data.cmd;
      cyl_nxt  = q_data.cyl;
      ovf_nxt  = q_data.cyl_ovf;
      head_nxt = q_data.head;
      sect_nxt = q_data.sect;
      left_nxt = q_data.count;
      done_nxt = 6'd0;
    end
    if (pop) ovalid_nxt = 1'b0;
    if (load) begin
      ovalid_nxt                = 1'b1;
      out_nxt.function_word     = {(cmd_r == CMD_WRITE) ? FUNC_WRITE_HI : FUNC_READ_HI,
                                   2'b00, run};
      out_nxt.cyl_sector_word   = {cyl_r[7:0], cyl_r[9:8], sect_r + 6'd1};
      out_nxt.head_drive_word   = {head_r, geo.drive};
      out_nxt.cylinder          = cyl_r;
      out_nxt.head              = head_r;
      out_nxt.sector            = sect_r;
      out_nxt.run_sectors       = run;
      out_nxt.buffer_offset     = done_r[4:0];
      out_nxt.last              = fin;
      out_nxt.cylinder_overflow = ovf_r;
      left_nxt                  = left_r - run;
      done_nxt                  = done_r + run;
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        sect_nxt = 6'd0;
        if (head_inc == geo.heads) begin
          head_nxt = 8'd0;
          cyl_nxt  = cyl_r + 10'd1;
          ovf_nxt  = ovf_r | (&cyl_r);
        end else begin
          head_nxt = head_inc[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cmd_r  <= cmd_nxt;
    cyl_r  <= cyl_nxt;
    ovf_r  <= ovf_nxt;
    head_r <= head_nxt;
    sect_r <= sect_nxt;
    left_r <= left_nxt;
    done_r <= done_nxt;
    out_r  <= out_nxt;
  end

  assign empty    = !ovalid_r;
  assign out_data = out_r;

  a_sect_in_track: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> sect_r < geo.spt)
    else $error("Run start sector outside the track.");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> out_r.run_sectors != 6'd0)
    else $error("Empty run presented.");

endmodule

### hw/rtl/lba_to_chs_track_transfer_planner.sv
// ----------------------------------------------------------------------------
// LBA to CHS track transfer planner
// Converts a linear sector request into per-track INT 13h style transfers.
//
//   Channel  Handshake               Payload
//   input    push / full             in_data  (cmd, start_sector, count)
//   result   empty / pop             out_data (one track run per transfer)
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request holds the front end while it is taken, the shared divider is
// started, two 32-step divider passes run, each ending with its result
// taken, and it is handed to the plan queue. A request with a zero count
// is dropped as it is taken. The back end emits one run per cycle while the
// result side pops, with a load gap between requests. Reset is synchronous
// and needs no clearing pass. A held result stalls only the back end; the
// front end keeps working until the two-entry plan queue fills.
// ----------------------------------------------------------------------------
module lba_to_chs_track_transfer_planner
  import ltc_pkg::*;
#(
  parameter int MAX_SECTORS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [8:0] head_count_r;
  logic [5:0] spt_r;
  logic [7:0] drive_r;
  geo_t       geo;
  logic       qp_push;
  logic       qp_full;
  plan_t      qp_wdata;
  logic       qp_pop;
  logic       qp_empty;
  plan_t      qp_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r <= RST_HEAD_COUNT;
      spt_r        <= RST_SPT;
      drive_r      <= RST_DRIVE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEAD_COUNT: head_count_r <= cfg_data[8:0];
        REG_SPT:        spt_r        <= cfg_data[5:0];
        REG_DRIVE:      drive_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign geo = '{heads: eff_heads(head_count_r), spt: eff_spt(spt_r), drive: drive_r};

  ltc_front #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .geo     (geo),
    .q_push  (qp_push),
    .q_full  (qp_full),
    .q_data  (qp_wdata)
  );

  ltc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qp_push),
    .full  (qp_full),
    .wdata (qp_wdata),
    .pop   (qp_pop),
    .empty (qp_empty),
    .rdata (qp_rdata)
  );

  ltc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (qp_rdata),
    .q_empty  (qp_empty),
    .q_pop    (qp_pop),
    .geo      (geo),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

### tb/ltc_track_run_checker.sv
// ----------------------------------------------------------------------------
// Track run checker for the LBA to CHS planner
// Mirrors the geometry registers from the config channel, plans the expected
// track runs of every request taken on the input side and compares each run
// popped from the result side, field by field, against the oldest one due.
// ----------------------------------------------------------------------------
module ltc_track_run_checker
  import ltc_pkg::*;
#(
  parameter int MAX_SECTORS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  in_item_t              in_data,
  input  logic                  empty,
  input  logic                  pop,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    runs_pending,
  output int                    runs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [9:0]  FUNC_READ_BASE  = 10'h200;
  localparam logic [9:0]  FUNC_WRITE_BASE = 10'h300;
  localparam logic [63:0] CYL_PACK_MAX    = 64'd1023;

  logic [8:0] geo_heads;
  logic [5:0] geo_spt;
  logic [7:0] geo_drive;
  out_item_t  runs_due[$];

  initial begin
    mismatches   = 0;
    runs_pending = 0;
    runs_checked = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  function automatic void plan_track_runs(input in_item_t req);
    logic [63:0] heads, spt, per_cyl, cyl, rem, head, sect, left, run, done;
    logic [9:0]  c10;
    out_item_t   r;
    heads   = (geo_heads == 9'd0) ? 64'd1 : (geo_heads > 9'd256) ? 64'd256 : 64'(geo_heads);
    spt     = (geo_spt == 6'd0) ? 64'd1 : 64'(geo_spt);
    per_cyl = heads * spt;
    left    = (req.request_sectors > MAX_SECTORS) ? 64'(MAX_SECTORS)
                                                  : 64'(req.request_sectors);
    cyl  = 64'(req.start_sector) / per_cyl;
    rem  = 64'(req.start_sector) % per_cyl;
    sect = rem % spt;
    head = rem / spt;
    done = 64'd0;
    while (left != 64'd0) begin
      run = (spt - sect < left) ? spt - sect : left;
      c10 = cyl[9:0];
      r.function_word     = ((req.cmd == CMD_WRITE) ? FUNC_WRITE_BASE : FUNC_READ_BASE)
                            + run[9:0];
      r.cyl_sector_word   = {c10[7:0], c10[9:8], 6'd0} + sect[15:0] + 16'd1;
      r.head_drive_word   = {8'd0, geo_drive} + {head[7:0], 8'd0};
      r.cylinder          = c10;
      r.head              = head[7:0];
      r.sector            = sect[5:0];
      r.run_sectors       = run[5:0];
      r.buffer_offset     = done[4:0];
      r.last              = (run == left);
      r.cylinder_overflow = (cyl > CYL_PACK_MAX);
      runs_due.push_back(r);
      left = left - run;
      done = done + run;
      if (!r.last) begin
        sect = 64'd0;
        head = head + 64'd1;
        if (head == heads) begin
          head = 64'd0;
          cyl  = cyl + 64'd1;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      geo_heads = RST_HEAD_COUNT;
      geo_spt   = RST_SPT;
      geo_drive = RST_DRIVE;
      runs_due.delete();
    end else begin
      if (pop && empty === 1'b0) begin
        runs_checked++;
        if (runs_due.size() == 0) begin
          flag_mismatch($sformatf("result transfer %0h with no run due", out_data));
        end else begin
          want = runs_due.pop_front();
          check_field("function_word", 16'(out_data.function_word), 16'(want.function_word));
          check_field("cyl_sector_word", out_data.cyl_sector_word, want.cyl_sector_word);
          check_field("head_drive_word", out_data.head_drive_word, want.head_drive_word);
          check_field("cylinder", 16'(out_data.cylinder), 16'(want.cylinder));
          check_field("head", 16'(out_data.head), 16'(want.head));
          check_field("sector", 16'(out_data.sector), 16'(want.sector));
          check_field("run_sectors", 16'(out_data.run_sectors), 16'(want.run_sectors));
          check_field("buffer_offset", 16'(out_data.buffer_offset), 16'(want.buffer_offset));
          check_field("last", 16'(out_data.last), 16'(want.last));
          check_field("cylinder_overflow", 16'(out_data.cylinder_overflow),
                      16'(want.cylinder_overflow));
        end
      end
      if (push && full === 1'b0) plan_track_runs(in_data);
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_HEAD_COUNT: geo_heads = cfg_data;
          REG_SPT:        geo_spt   = cfg_data[5:0];
          REG_DRIVE:      geo_drive = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    runs_pending = runs_due.size();
  end

endmodule

### tb/tb_lba_to_chs_track_transfer_planner.sv
// ----------------------------------------------------------------------------
// Testbench for the LBA to CHS track transfer planner
// Sends directed and random transfer requests under a series of drive
// geometries, with bursty input, a randomly stalling result side and one long
// result hold-off, and lets the track run checker judge every run.
// ----------------------------------------------------------------------------
module tb_lba_to_chs_track_transfer_planner
  import ltc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   MAX_SECTORS     = 32;
  localparam int                   FRONT_END_DRAIN = 80;
  localparam int                   END_DRAIN       = 100;
  localparam int                   LONG_HOLD       = 600;
  localparam logic                 DIR_READ        = 1'b0;
  localparam logic                 DIR_WRITE       = CMD_WRITE;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  in_item_t              in_data;
  logic                  empty;
  logic                  pop;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          mismatches;
  int          runs_pending;
  int          runs_checked;
  int          burst_left;
  int          hold_requests;
  int          requests_sent;
  int          zero_requests;
  int          cfg_writes;
  int          geometries;
  int unsigned cyl_span;
  int unsigned track_span;

  lba_to_chs_track_transfer_planner #(.MAX_SECTORS(MAX_SECTORS)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ltc_track_run_checker #(.MAX_SECTORS(MAX_SECTORS)) run_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .runs_pending(runs_pending), .runs_checked(runs_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Timed out with %0d runs still due.", runs_pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int holds_done;
    int mode;
    int stretch;
    holds_done = 0;
    pop = 1'b0;
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          pop <= 1'b0;
        end
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          @(negedge clk);
          case (mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  task automatic send_request(input logic dir, input logic [31:0] start,
                              input logic [5:0] count);
    in_item_t item;
    item.cmd             = dir;
    item.start_sector    = start;
    item.request_sectors = count;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (full !== 1'b0);
    requests_sent++;
    if (count == 6'd0) zero_requests++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 15)) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (FRONT_END_DRAIN) @(negedge clk);
    burst_left = $urandom_range(1, 24);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [8:0] heads, input logic [8:0] spt,
                              input logic [8:0] drive);
    int unsigned eff_h;
    int unsigned eff_s;
    wait_idle();
    cfg_write(REG_HEAD_COUNT, heads);
    cfg_write(REG_SPT, spt);
    cfg_write(REG_DRIVE, drive);
    eff_h      = (heads == 9'd0) ? 1 : (heads > 9'd256) ? 256 : heads;
    eff_s      = (spt[5:0] == 6'd0) ? 1 : spt[5:0];
    track_span = eff_s;
    cyl_span   = eff_h * eff_s;
    geometries++;
  endtask

  function automatic logic [31:0] random_start();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return $urandom_range(0, 20000);
      5, 6:    return $urandom_range(1000, 1030) * cyl_span - $urandom_range(0, 40);
      7:       return ($urandom_range(0, 1 << 20) + 1) * track_span - $urandom_range(1, 3);
      8:       return 32'hFFFF_FFFF - $urandom_range(0, 200);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [5:0] random_count();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'(MAX_SECTORS);
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  task automatic random_requests(input int n);
    repeat (n) send_request(1'($urandom_range(0, 1)), random_start(), random_count());
  endtask

  task automatic edge_requests();
    send_request(DIR_READ, 32'd0, 6'd32);
    send_request(DIR_WRITE, track_span - 1, 6'd32);
    send_request(DIR_READ, cyl_span - 1, 6'd2);
    send_request(DIR_WRITE, 1024 * cyl_span - 1, 6'd32);
    send_request(DIR_READ, 32'hFFFF_FFFF, 6'd63);
    send_request(DIR_WRITE, $urandom(), 6'd0);
  endtask

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    burst_left    = 8;
    hold_requests = 0;
    requests_sent = 0;
    zero_requests = 0;
    cfg_writes    = 0;
    geometries    = 1;
    track_span    = RST_SPT;
    cyl_span      = RST_HEAD_COUNT * RST_SPT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(DIR_READ, 32'd0, 6'd1);
    send_request(DIR_WRITE, 32'd0, 6'd32);
    send_request(DIR_READ, 32'd5, 6'd0);
    send_request(DIR_WRITE, 32'd1000, 6'd63);
    send_request(DIR_READ, 32'd62, 6'd33);
    send_request(DIR_WRITE, 32'd1007, 6'd5);
    send_request(DIR_READ, 32'd1032189, 6'd10);
    send_request(DIR_WRITE, 32'd1031184, 6'd32);
    send_request(DIR_READ, 32'hAAAA_AAAA, 6'b010101);
    send_request(DIR_WRITE, 32'h5555_5555, 6'b101010);
    send_request(DIR_READ, 32'h8000_0000, 6'd31);
    send_request(DIR_WRITE, 32'hFFFF_FFFF, 6'd1);
    edge_requests();
    random_requests(40);

    set_geometry(9'd1, 9'd1, 9'd0);
    edge_requests();
    random_requests(60);

    set_geometry(9'd256, 9'd63, 9'd255);
    hold_requests++;
    burst_left = 40;
    random_requests(70);

    set_geometry(9'd0, 9'h040, 9'h1FF);
    edge_requests();
    random_requests(50);

    set_geometry(9'd511, 9'h1FF, 9'h100);
    cfg_write(REG_UNUSED, 9'($urandom_range(0, 511)));
    edge_requests();
    random_requests(50);

    repeat (4) begin
      set_geometry(9'($urandom_range(0, 300)), 9'($urandom_range(0, 511)),
                   9'($urandom_range(0, 511)));
      edge_requests();
      random_requests(50);
    end

    @(negedge clk);
    push <= 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (END_DRAIN) @(negedge clk);

    $display("Sent %0d requests (%0d of zero length) across %0d geometries, %0d register writes.",
             requests_sent, zero_requests, geometries, cfg_writes);
    $display("Checked %0d track runs with %0d mismatches.", runs_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
